// ===== rtl/osa_pkg.sv =====
// Shared types, codes and class tables for the open interval set algebra block.
package osa_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int VAL_W       = 64;
   localparam int CLASS_W     = 6;
   localparam int ACTION_W    = 3;

   typedef enum logic [ACTION_W-1:0] {
      ACT_UNION     = 3'd0,
      ACT_DIFF      = 3'd1,
      ACT_ISECT     = 3'd2,
      ACT_CLOSURE   = 3'd3,
      ACT_INTERSECT = 3'd4,
      ACT_INSIDE    = 3'd5
   } act_type;

   typedef enum logic [3:0] {
      OP_NONE = 4'd0,
      OP_A1B2 = 4'd1,
      OP_B1A2 = 4'd2,
      OP_CPYA = 4'd3,
      OP_CPYB = 4'd4,
      OP_A2A2 = 4'd5,
      OP_B2B2 = 4'd6,
      OP_A1B1 = 4'd7,
      OP_B2A2 = 4'd8
   } op_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] lo;
      logic signed [VAL_W-1:0] hi;
      logic                    lf;
      logic                    hf;
      logic                    sl;
   } ivl_type;

   typedef struct packed {
      logic alo_lt_blo;
      logic alo_eq_blo;
      logic ahi_lt_bhi;
      logic ahi_eq_bhi;
      logic ahi_lt_blo;
      logic ahi_eq_blo;
      logic alo_lt_bhi;
      logic alo_eq_bhi;
      logic alo_gt_ahi;
      logic blo_gt_bhi;
   } cmp_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      ivl_type             a;
      ivl_type             b;
      cmp_type             cmp;
      logic [CLASS_W-1:0]  cls;
   } work_type;

   typedef struct packed {
      ivl_type            r;
      logic [CLASS_W-1:0] cls;
      logic               flag;
      logic               status;
   } res_type;

   localparam op_type UNION_TAB [0:52] = '{
      OP_NONE,
      OP_NONE, OP_A1B2, OP_CPYA, OP_B1A2, OP_CPYB, OP_NONE, OP_A1B2, OP_B1A2, OP_A1B2, OP_B1A2,
      OP_CPYA, OP_A1B2, OP_B1A2, OP_CPYA, OP_CPYA, OP_NONE, OP_B1A2, OP_B1A2, OP_CPYA, OP_CPYA,
      OP_NONE, OP_A1B2, OP_A1B2, OP_CPYB, OP_CPYB, OP_NONE, OP_A1B2, OP_A1B2, OP_CPYB, OP_CPYB,
      OP_NONE, OP_B1A2, OP_B1A2, OP_NONE, OP_A1B2, OP_A1B2, OP_NONE, OP_B1A2, OP_B1A2, OP_CPYB,
      OP_CPYA, OP_CPYA, OP_CPYA, OP_CPYA, OP_CPYB, OP_CPYA, OP_CPYB, OP_CPYA, OP_CPYA, OP_CPYB,
      OP_CPYB, OP_CPYA
   };

   localparam op_type DIFF_TAB [0:52] = '{
      OP_NONE,
      OP_CPYA, OP_A1B1, OP_NONE, OP_B2A2, OP_NONE, OP_CPYA, OP_CPYA, OP_CPYA, OP_A1B1, OP_B2A2,
      OP_NONE, OP_NONE, OP_NONE, OP_NONE, OP_B2A2, OP_CPYA, OP_CPYA, OP_B2A2, OP_NONE, OP_A1B1,
      OP_CPYA, OP_CPYA, OP_A1B1, OP_NONE, OP_NONE, OP_CPYA, OP_CPYA, OP_A1B1, OP_NONE, OP_NONE,
      OP_CPYA, OP_CPYA, OP_B2A2, OP_CPYA, OP_CPYA, OP_A1B1, OP_CPYA, OP_CPYA, OP_A1B1, OP_NONE,
      OP_NONE, OP_B2A2, OP_A1B1, OP_NONE, OP_NONE, OP_NONE, OP_NONE, OP_B2A2, OP_A1B1, OP_NONE,
      OP_NONE, OP_NONE
   };

   localparam op_type ISECT_TAB [0:52] = '{
      OP_NONE,
      OP_NONE, OP_B1A2, OP_CPYB, OP_A1B2, OP_CPYA, OP_NONE, OP_A2A2, OP_B2B2, OP_CPYB, OP_CPYB,
      OP_CPYA, OP_CPYA, OP_CPYA, OP_CPYB, OP_CPYB, OP_NONE, OP_B2B2, OP_A1B2, OP_CPYB, OP_CPYB,
      OP_NONE, OP_A2A2, OP_B1A2, OP_CPYA, OP_CPYA, OP_NONE, OP_A2A2, OP_B1A2, OP_CPYA, OP_CPYA,
      OP_NONE, OP_B2B2, OP_A1B2, OP_NONE, OP_A2A2, OP_B1A2, OP_NONE, OP_B2B2, OP_A1B2, OP_CPYA,
      OP_CPYA, OP_CPYB, OP_CPYB, OP_CPYA, OP_CPYA, OP_CPYB, OP_CPYA, OP_CPYB, OP_CPYB, OP_CPYA,
      OP_CPYA, OP_CPYA
   };

   localparam logic INSIDE_TAB [0:52] = '{
      1'b0,
      1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
      1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1,
      1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1,
      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1,
      1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
      1'b1, 1'b1
   };

endpackage

// ===== rtl/osa_front.sv =====
// Front end: masks open bounds, compares the bounds and sorts the pair into its relation class.
module osa_front (
   input  logic                                  push,
   output logic                                  full,
   input  logic [osa_pkg::ACTION_W-1:0]          req_action,
   input  logic signed [osa_pkg::VAL_W-1:0]      req_a_low,
   input  logic signed [osa_pkg::VAL_W-1:0]      req_a_high,
   input  logic                                  req_a_low_closed,
   input  logic                                  req_a_high_closed,
   input  logic                                  req_a_is_slice,
   input  logic signed [osa_pkg::VAL_W-1:0]      req_b_low,
   input  logic signed [osa_pkg::VAL_W-1:0]      req_b_high,
   input  logic                                  req_b_low_closed,
   input  logic                                  req_b_high_closed,
   input  logic                                  req_b_is_slice,
   input  logic                                  q_full,
   output logic                                  q_wr_en,
   output osa_pkg::work_type                     q_wr_data
);
   import osa_pkg::*;

   ivl_type            a;
   ivl_type            b;
   cmp_type            c;
   logic [3:0]         k;
   logic [CLASS_W-1:0] cls;
   logic               alo_gt_blo;
   logic               alo_gt_bhi;
   logic               ahi_gt_bhi;

   function automatic logic [CLASS_W-1:0] pick(input logic lt, input logic eq,
                                               input logic [CLASS_W-1:0] x,
                                               input logic [CLASS_W-1:0] y,
                                               input logic [CLASS_W-1:0] z);
      return lt ? x : (eq ? y : z);
   endfunction

   always_comb begin
      a.lf = req_a_low_closed;
      a.hf = req_a_high_closed;
      a.sl = req_a_is_slice;
      a.lo = a.lf ? req_a_low : '0;
      a.hi = a.hf ? req_a_high : '0;
      b.lf = req_b_low_closed;
      b.hf = req_b_high_closed;
      b.sl = req_b_is_slice;
      b.lo = b.lf ? req_b_low : '0;
      b.hi = b.hf ? req_b_high : '0;

      c.alo_lt_blo = $signed(a.lo) < $signed(b.lo);
      c.alo_eq_blo = a.lo == b.lo;
      c.ahi_lt_bhi = $signed(a.hi) < $signed(b.hi);
      c.ahi_eq_bhi = a.hi == b.hi;
      c.ahi_lt_blo = $signed(a.hi) < $signed(b.lo);
      c.ahi_eq_blo = a.hi == b.lo;
      c.alo_lt_bhi = $signed(a.lo) < $signed(b.hi);
      c.alo_eq_bhi = a.lo == b.hi;
      c.alo_gt_ahi = $signed(a.lo) > $signed(a.hi);
      c.blo_gt_bhi = $signed(b.lo) > $signed(b.hi);

      alo_gt_blo = !c.alo_lt_blo && !c.alo_eq_blo;
      alo_gt_bhi = !c.alo_lt_bhi && !c.alo_eq_bhi;
      ahi_gt_bhi = !c.ahi_lt_bhi && !c.ahi_eq_bhi;

      k = {a.lf, a.hf, b.lf, b.hf};
      case (k)
         4'b1111: begin
            if (c.alo_lt_blo) begin
               if (c.ahi_lt_bhi) cls = pick(c.ahi_lt_blo, c.ahi_eq_blo, 6'd1, 6'd7, 6'd2);
               else cls = c.ahi_eq_bhi ? 6'd9 : 6'd3;
            end else if (c.alo_eq_blo) begin
               cls = pick(c.ahi_lt_bhi, c.ahi_eq_bhi, 6'd12, 6'd11, 6'd10);
            end else if (c.ahi_lt_bhi) begin
               cls = 6'd5;
            end else if (c.ahi_eq_bhi) begin
               cls = 6'd13;
            end else begin
               cls = pick(c.alo_lt_bhi, c.alo_eq_bhi, 6'd4, 6'd8, 6'd6);
            end
         end
         4'b1011: begin
            if (c.alo_lt_blo) cls = 6'd14;
            else if (c.alo_eq_blo) cls = 6'd15;
            else cls = pick(alo_gt_bhi, c.alo_eq_bhi, 6'd16, 6'd17, 6'd18);
         end
         4'b0111: begin
            if (ahi_gt_bhi) cls = 6'd19;
            else if (c.ahi_eq_bhi) cls = 6'd20;
            else cls = pick(c.ahi_lt_blo, c.ahi_eq_blo, 6'd21, 6'd22, 6'd23);
         end
         4'b1110: begin
            if (alo_gt_blo) cls = 6'd24;
            else if (c.alo_eq_blo) cls = 6'd25;
            else cls = pick(c.ahi_lt_blo, c.ahi_eq_blo, 6'd26, 6'd27, 6'd28);
         end
         4'b1101: begin
            if (c.ahi_lt_bhi) cls = 6'd29;
            else if (c.ahi_eq_bhi) cls = 6'd30;
            else cls = pick(alo_gt_bhi, c.alo_eq_bhi, 6'd31, 6'd32, 6'd33);
         end
         4'b0110: cls = pick(c.ahi_lt_blo, c.ahi_eq_blo, 6'd34, 6'd35, 6'd36);
         4'b1001: cls = pick(alo_gt_bhi, c.alo_eq_bhi, 6'd37, 6'd38, 6'd39);
         4'b0101: cls = pick(c.ahi_lt_bhi, c.ahi_eq_bhi, 6'd40, 6'd41, 6'd42);
         4'b1010: cls = pick(c.alo_lt_blo, c.alo_eq_blo, 6'd43, 6'd44, 6'd45);
         4'b0011: cls = 6'd46;
         4'b1100: cls = 6'd47;
         4'b0001: cls = 6'd48;
         4'b0010: cls = 6'd49;
         4'b0100: cls = 6'd50;
         4'b1000: cls = 6'd51;
         default: cls = 6'd52;
      endcase

      q_wr_data.action = req_action;
      q_wr_data.a      = a;
      q_wr_data.b      = b;
      q_wr_data.cmp    = c;
      q_wr_data.cls    = cls;
   end

   assign full    = q_full;
   assign q_wr_en = push && !q_full;

endmodule

// ===== rtl/osa_queue.sv =====
// Two-entry work queue between the classifier and the result builder.
module osa_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  osa_pkg::work_type wr_data,
   output logic              full,
   input  logic              rd_en,
   output osa_pkg::work_type rd_data,
   output logic              empty
);
   import osa_pkg::*;

   work_type           mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff;
   logic [CNT_W-1:0]   cnt_in;

   always_comb begin
      wr_ptr_in = wr_en ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = rd_en ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + CNT_W'(wr_en) - CNT_W'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_data = mem_ff[rd_ptr_ff];
   assign full    = cnt_ff == CNT_W'(QUEUE_DEPTH);
   assign empty   = cnt_ff == '0;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("work queue count exceeds depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !wr_en)
      else $error("write into full work queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !rd_en)
      else $error("read from empty work queue");

endmodule

// ===== rtl/osa_back.sv =====
// Back end: builds the result interval from the class tables and holds results for the reader.
module osa_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  q_empty,
   input  osa_pkg::work_type                     q_rd_data,
   output logic                                  q_rd_en,
   input  logic                                  pop,
   output logic                                  empty,
   output logic signed [osa_pkg::VAL_W-1:0]      rsp_res_low,
   output logic signed [osa_pkg::VAL_W-1:0]      rsp_res_high,
   output logic                                  rsp_res_low_closed,
   output logic                                  rsp_res_high_closed,
   output logic                                  rsp_res_is_slice,
   output logic [osa_pkg::CLASS_W-1:0]           rsp_relation_class,
   output logic                                  rsp_test_flag,
   output logic                                  rsp_status
);
   import osa_pkg::*;

   work_type         w;
   ivl_type          a;
   ivl_type          b;
   cmp_type          c;
   op_type           op;
   ivl_type          built;
   logic             bad;
   logic             close_bad;
   res_type          res;
   res_type          head;

   res_type          out_mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic             load;
   logic             take;

   always_comb begin
      w = q_rd_data;
      a = w.a;
      b = w.b;
      c = w.cmp;

      case (act_type'(w.action))
         ACT_UNION: op = UNION_TAB[w.cls];
         ACT_DIFF:  op = DIFF_TAB[w.cls];
         ACT_ISECT: op = ISECT_TAB[w.cls];
         default:   op = OP_NONE;
      endcase

      built = '0;
      bad   = 1'b0;
      case (op)
         OP_A1B2: begin
            built.lf = a.lf; built.lo = a.lo; built.hf = b.hf; built.hi = b.hi;
            bad = a.lf && b.hf && !c.alo_lt_bhi && !c.alo_eq_bhi;
         end
         OP_B1A2: begin
            built.lf = b.lf; built.lo = b.lo; built.hf = a.hf; built.hi = a.hi;
            bad = b.lf && a.hf && c.ahi_lt_blo;
         end
         OP_A1B1: begin
            built.lf = a.lf; built.lo = a.lo; built.hf = b.lf; built.hi = b.lo;
            bad = a.lf && b.lf && !c.alo_lt_blo && !c.alo_eq_blo;
         end
         OP_B2A2: begin
            built.lf = b.hf; built.lo = b.hi; built.hf = a.hf; built.hi = a.hi;
            bad = b.hf && a.hf && c.ahi_lt_bhi;
         end
         OP_A2A2: begin
            built.lf = a.hf; built.lo = a.hi; built.hf = a.hf; built.hi = a.hi;
         end
         OP_B2B2: begin
            built.lf = b.hf; built.lo = b.hi; built.hf = b.hf; built.hi = b.hi;
         end
         OP_CPYA: built = a;
         OP_CPYB: built = b;
         default: bad = 1'b1;
      endcase

      close_bad = a.lf && b.lf && a.hf && b.hf && c.alo_gt_ahi && c.ahi_lt_blo
                  && !c.alo_lt_bhi && !c.alo_eq_bhi && c.blo_gt_bhi;

      res        = '0;
      res.cls    = w.cls;
      case (act_type'(w.action))
         ACT_UNION: begin
            res.status = bad;
            if (!bad) begin
               res.r    = built;
               res.r.sl = built.sl || (a.sl && b.sl);
            end
         end
         ACT_DIFF: begin
            res.status = bad;
            if (!bad) res.r = built;
         end
         ACT_ISECT: begin
            res.status = bad;
            if (!bad) begin
               res.r    = built;
               res.r.sl = built.sl || a.sl || b.sl;
            end
         end
         ACT_CLOSURE: begin
            res.status = close_bad;
            if (!close_bad) begin
               res.r.lf = a.lf && b.lf;
               res.r.hf = a.hf && b.hf;
               res.r.lo = res.r.lf ? (c.alo_lt_blo ? a.lo : b.lo) : '0;
               res.r.hi = res.r.hf ? (c.ahi_lt_bhi ? b.hi : a.hi) : '0;
            end
         end
         ACT_INTERSECT: res.flag = UNION_TAB[w.cls] != OP_NONE;
         ACT_INSIDE:    res.flag = INSIDE_TAB[w.cls];
         default:       res.status = 1'b1;
      endcase
   end

   always_comb begin
      load      = !q_empty && (cnt_ff != CNT_W'(QUEUE_DEPTH));
      take      = pop && (cnt_ff != '0);
      wr_ptr_in = load ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = take ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + CNT_W'(load) - CNT_W'(take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_mem_ff[wr_ptr_ff] <= res;
      end
   end

   assign q_rd_en             = load;
   assign head                = out_mem_ff[rd_ptr_ff];
   assign empty               = cnt_ff == '0;
   assign rsp_res_low         = head.r.lo;
   assign rsp_res_high        = head.r.hi;
   assign rsp_res_low_closed  = head.r.lf;
   assign rsp_res_high_closed = head.r.hf;
   assign rsp_res_is_slice    = head.r.sl;
   assign rsp_relation_class  = head.cls;
   assign rsp_test_flag       = head.flag;
   assign rsp_status          = head.status;

   a_status_clears: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_status) |-> (rsp_res_low == '0 && rsp_res_high == '0
         && !rsp_res_low_closed && !rsp_res_high_closed && !rsp_res_is_slice
         && !rsp_test_flag))
      else $error("failed transaction carries result fields");

   a_open_reads_zero: assert property (@(posedge clock) disable iff (reset)
      !empty |-> ((rsp_res_low_closed || rsp_res_low == '0)
         && (rsp_res_high_closed || rsp_res_high == '0)))
      else $error("open bound reads back nonzero");

   a_class_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_relation_class != '0 && rsp_relation_class <= CLASS_W'(52)))
      else $error("relation class out of range");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == CNT_W'(1) && take && !load) |=> empty)
      else $error("result buffer failed to drain");

endmodule

// ===== rtl/open_interval_set_algebra.sv =====
// Top level of the open interval set algebra block: classifier, work queue and result builder.
// A request is classified into the work queue, then built into the result buffer behind rsp_.
// One transaction per cycle unless a buffer is full; classify and build are combinational.
// full comes from the two-entry work queue, empty from the two-entry result buffer.
// Reset clears the queue pointers and counts; stored payloads are left as they are.
module open_interval_set_algebra (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  push,
   output logic                                  full,
   input  logic [osa_pkg::ACTION_W-1:0]          req_action,
   input  logic signed [osa_pkg::VAL_W-1:0]      req_a_low,
   input  logic signed [osa_pkg::VAL_W-1:0]      req_a_high,
   input  logic                                  req_a_low_closed,
   input  logic                                  req_a_high_closed,
   input  logic                                  req_a_is_slice,
   input  logic signed [osa_pkg::VAL_W-1:0]      req_b_low,
   input  logic signed [osa_pkg::VAL_W-1:0]      req_b_high,
   input  logic                                  req_b_low_closed,
   input  logic                                  req_b_high_closed,
   input  logic                                  req_b_is_slice,
   output logic                                  empty,
   input  logic                                  pop,
   output logic signed [osa_pkg::VAL_W-1:0]      rsp_res_low,
   output logic signed [osa_pkg::VAL_W-1:0]      rsp_res_high,
   output logic                                  rsp_res_low_closed,
   output logic                                  rsp_res_high_closed,
   output logic                                  rsp_res_is_slice,
   output logic [osa_pkg::CLASS_W-1:0]           rsp_relation_class,
   output logic                                  rsp_test_flag,
   output logic                                  rsp_status
);
   import osa_pkg::*;

   logic     q_wr_en;
   work_type q_wr_data;
   logic     q_full;
   logic     q_rd_en;
   work_type q_rd_data;
   logic     q_empty;

   osa_front u_front (
      .push              (push),
      .full              (full),
      .req_action        (req_action),
      .req_a_low         (req_a_low),
      .req_a_high        (req_a_high),
      .req_a_low_closed  (req_a_low_closed),
      .req_a_high_closed (req_a_high_closed),
      .req_a_is_slice    (req_a_is_slice),
      .req_b_low         (req_b_low),
      .req_b_high        (req_b_high),
      .req_b_low_closed  (req_b_low_closed),
      .req_b_high_closed (req_b_high_closed),
      .req_b_is_slice    (req_b_is_slice),
      .q_full            (q_full),
      .q_wr_en           (q_wr_en),
      .q_wr_data         (q_wr_data)
   );

   osa_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_wr_en),
      .wr_data (q_wr_data),
      .full    (q_full),
      .rd_en   (q_rd_en),
      .rd_data (q_rd_data),
      .empty   (q_empty)
   );

   osa_back u_back (
      .clock               (clock),
      .reset               (reset),
      .q_empty             (q_empty),
      .q_rd_data           (q_rd_data),
      .q_rd_en             (q_rd_en),
      .pop                 (pop),
      .empty               (empty),
      .rsp_res_low         (rsp_res_low),
      .rsp_res_high        (rsp_res_high),
      .rsp_res_low_closed  (rsp_res_low_closed),
      .rsp_res_high_closed (rsp_res_high_closed),
      .rsp_res_is_slice    (rsp_res_is_slice),
      .rsp_relation_class  (rsp_relation_class),
      .rsp_test_flag       (rsp_test_flag),
      .rsp_status          (rsp_status)
   );

endmodule
